// ===== hw/rtl/plsm_pkg.sv =====
// Shared types and constants of the pin logic stack machine.
package plsm_pkg;

  // Default number of operand stack entries.
  localparam int unsigned STACK_DEPTH_DEF = 16;
  // Number of program lines the fetch side can address.
  localparam int unsigned PROGRAM_LINES = 256;

  // Widths fixed by the item fields.
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned ARG_W    = 8;
  localparam int unsigned LINE_W   = 8;
  localparam int unsigned FAULT_W  = 2;
  localparam int unsigned PLEN_W   = 9;
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_READ = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_SET  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_OR   = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_AND  = 3'd3;

  // Fault codes.
  localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
  localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd1;
  localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd2;

  // Register index decoded from the configuration address.
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  // What a stack cell does in a cycle.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_ABOVE,
    CELL_FROM_BELOW
  } cell_cmd_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_e;

endpackage

// ===== hw/rtl/plsm_if.sv =====
// Handshake interfaces for instruction beats and result beats.
interface plsm_in_if;
  logic                               valid;
  logic                               ready;
  logic [plsm_pkg::OPCODE_W-1:0]      opcode;
  logic [plsm_pkg::ARG_W-1:0]         instr_arg;
  logic [plsm_pkg::WORD_W-1:0]        pin_value;

  modport source (output valid, output opcode, output instr_arg, output pin_value,
                  input ready);
  modport sink   (input valid, input opcode, input instr_arg, input pin_value,
                  output ready);
endinterface

interface plsm_out_if;
  logic                               valid;
  logic                               ready;
  logic                               pin_write_enable;
  logic [plsm_pkg::ARG_W-1:0]         pin_index;
  logic [plsm_pkg::WORD_W-1:0]        pin_write_value;
  logic [plsm_pkg::LINE_W-1:0]        next_line;
  logic [plsm_pkg::FAULT_W-1:0]       fault;

  modport source (output valid, output pin_write_enable, output pin_index,
                  output pin_write_value, output next_line, output fault,
                  input ready);
  modport sink   (input valid, input pin_write_enable, input pin_index,
                  input pin_write_value, input next_line, input fault,
                  output ready);
endinterface

// ===== hw/rtl/plsm_cell.sv =====
// One operand stack cell: holds a word or takes it from a neighbour.
module plsm_cell (
  input  logic                          clk_i,
  input  plsm_pkg::cell_cmd_e           cmd_i,
  input  logic [plsm_pkg::WORD_W-1:0]   above_i,
  input  logic [plsm_pkg::WORD_W-1:0]   below_i,
  output logic [plsm_pkg::WORD_W-1:0]   value_o
);

  logic [plsm_pkg::WORD_W-1:0] value_q, value_d;

  // Select the word this cell keeps for the next cycle.
  always_comb begin
    case (cmd_i)
      plsm_pkg::CELL_FROM_ABOVE: value_d = above_i;
      plsm_pkg::CELL_FROM_BELOW: value_d = below_i;
      default:                   value_d = value_q;
    endcase
  end

  // Payload only, so no reset.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== hw/rtl/pin_logic_stack_machine.sv =====
// Pin logic stack machine: a row of stack cells with top at cell 0, and its sequencer.
// Timing: read, set, no-op, faulted and single-word or/and items deliver their result beat
// in the cycle after acceptance; an or/and of n words (n up to the stack depth) first merges
// its words one pair a cycle, and no new item is taken until the merge ends. Otherwise one
// item per cycle: a new item is taken once the output register is empty or its beat leaves.
// Reset clears stack depth, line counter and output valid, and sets program length to 1.
module pin_logic_stack_machine #(
  parameter int unsigned STACK_DEPTH = plsm_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  plsm_in_if.sink                        in_i,
  plsm_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plsm_pkg::PADDR_W-1:0]   paddr,
  input  logic [plsm_pkg::PDATA_W-1:0]   pwdata,
  output logic [plsm_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned W  = plsm_pkg::WORD_W;

  plsm_pkg::state_e             state_q, state_d;
  logic [DW-1:0]                depth_q, depth_d;
  logic [plsm_pkg::LINE_W-1:0]  line_q, line_d;
  logic [plsm_pkg::PLEN_W-1:0]  plen_q;
  logic [plsm_pkg::ARG_W-1:0]   cnt_q, cnt_d;
  logic                         is_and_q, is_and_d;

  logic                         ov_q, ov_d;
  logic                         o_we_q, o_we_d;
  logic [plsm_pkg::ARG_W-1:0]   o_idx_q, o_idx_d;
  logic [W-1:0]                 o_wval_q, o_wval_d;
  logic [plsm_pkg::LINE_W-1:0]  o_line_q, o_line_d;
  logic [plsm_pkg::FAULT_W-1:0] o_fault_q, o_fault_d;
  logic                         load;

  logic                         in_ready, accept;
  logic [plsm_pkg::ARG_W-1:0]   n_ops;
  logic                         stack_full, stack_empty, short_stack;
  logic [plsm_pkg::PLEN_W-1:0]  line_inc;
  logic                         line_wrap;
  logic                         is_merge_op, start_merge;

  plsm_pkg::cell_cmd_e          cmd_top, cmd_rest;
  logic [W-1:0]                 top_in, merged;
  logic [W-1:0]                 cell_val [STACK_DEPTH];

  // Configuration port: program length at addresses with bit 2 clear, other addresses ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == plsm_pkg::REG_PROGRAM_LENGTH)
                ? {{(plsm_pkg::PDATA_W - plsm_pkg::PLEN_W){1'b0}}, plen_q}
                : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q <= plsm_pkg::PLEN_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == plsm_pkg::REG_PROGRAM_LENGTH)) begin
      plen_q <= pwdata[plsm_pkg::PLEN_W-1:0];
    end
  end

  // Input handshake: idle sequencer and a free or draining output register.
  assign in_ready   = (state_q == plsm_pkg::ST_IDLE) && (!ov_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  // Instruction decode.
  assign n_ops       = (in_i.instr_arg == '0) ? plsm_pkg::ARG_W'(1) : in_i.instr_arg;
  assign stack_full  = (depth_q == DW'(STACK_DEPTH));
  assign stack_empty = (depth_q == '0);
  assign short_stack = (9'(depth_q) < 9'(n_ops));
  assign is_merge_op = (in_i.opcode == plsm_pkg::OP_OR) ||
                       (in_i.opcode == plsm_pkg::OP_AND);
  assign start_merge = accept && is_merge_op && !short_stack && (n_ops != plsm_pkg::ARG_W'(1));

  // Line counter advances on every accepted item and wraps at the program length or at PROGRAM_LINES.
  assign line_inc  = {1'b0, line_q} + plsm_pkg::PLEN_W'(1);
  assign line_wrap = (line_inc >= plen_q) ||
                     (17'(line_inc) >= 17'(plsm_pkg::PROGRAM_LINES)) ||
                     line_inc[plsm_pkg::PLEN_W-1];
  assign line_d    = accept ? (line_wrap ? '0 : line_inc[plsm_pkg::LINE_W-1:0]) : line_q;

  // Two top words combined for one merge step.
  assign merged = is_and_q ? (cell_val[0] & cell_val[1]) : (cell_val[0] | cell_val[1]);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      plsm_pkg::ST_IDLE: begin
        if (start_merge) begin
          state_d = plsm_pkg::ST_MERGE;
        end
      end
      plsm_pkg::ST_MERGE: begin
        if (cnt_q == plsm_pkg::ARG_W'(1)) begin
          state_d = plsm_pkg::ST_IDLE;
        end
      end
      default: state_d = plsm_pkg::ST_IDLE;
    endcase
  end

  // Cell commands, stack depth and result fields.
  always_comb begin
    cmd_top   = plsm_pkg::CELL_HOLD;
    cmd_rest  = plsm_pkg::CELL_HOLD;
    top_in    = in_i.pin_value;
    depth_d   = depth_q;
    cnt_d     = cnt_q;
    is_and_d  = is_and_q;
    load      = 1'b0;
    o_we_d    = 1'b0;
    o_idx_d   = '0;
    o_wval_d  = '0;
    o_line_d  = line_d;
    o_fault_d = plsm_pkg::FAULT_NONE;
    case (state_q)
      plsm_pkg::ST_IDLE: begin
        if (accept) begin
          load = !start_merge;
          case (in_i.opcode)
            plsm_pkg::OP_READ: begin
              o_idx_d = in_i.instr_arg;
              if (stack_full) begin
                o_fault_d = plsm_pkg::FAULT_OVER;
              end else begin
                cmd_top  = plsm_pkg::CELL_FROM_ABOVE;
                cmd_rest = plsm_pkg::CELL_FROM_ABOVE;
                depth_d  = depth_q + DW'(1);
              end
            end
            plsm_pkg::OP_SET: begin
              o_idx_d = in_i.instr_arg;
              if (stack_empty) begin
                o_fault_d = plsm_pkg::FAULT_UNDER;
              end else begin
                cmd_top  = plsm_pkg::CELL_FROM_BELOW;
                cmd_rest = plsm_pkg::CELL_FROM_BELOW;
                depth_d  = depth_q - DW'(1);
                o_we_d   = 1'b1;
                o_wval_d = cell_val[0];
              end
            end
            plsm_pkg::OP_OR, plsm_pkg::OP_AND: begin
              if (short_stack) begin
                o_fault_d = plsm_pkg::FAULT_UNDER;
              end else begin
                cnt_d    = n_ops - plsm_pkg::ARG_W'(1);
                is_and_d = (in_i.opcode == plsm_pkg::OP_AND);
              end
            end
            default: begin
            end
          endcase
        end
      end
      plsm_pkg::ST_MERGE: begin
        top_in   = merged;
        cmd_top  = plsm_pkg::CELL_FROM_ABOVE;
        cmd_rest = plsm_pkg::CELL_FROM_BELOW;
        depth_d  = depth_q - DW'(1);
        cnt_d    = cnt_q - plsm_pkg::ARG_W'(1);
        o_line_d = line_q;
        load     = (cnt_q == plsm_pkg::ARG_W'(1));
      end
      default: begin
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    ov_d = ov_q;
    if (load) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= plsm_pkg::ST_IDLE;
      depth_q  <= '0;
      line_q   <= '0;
      cnt_q    <= '0;
      is_and_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      depth_q  <= depth_d;
      line_q   <= line_d;
      cnt_q    <= cnt_d;
      is_and_q <= is_and_d;
      ov_q     <= ov_d;
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      o_we_q    <= o_we_d;
      o_idx_q   <= o_idx_d;
      o_wval_q  <= o_wval_d;
      o_line_q  <= o_line_d;
      o_fault_q <= o_fault_d;
    end
  end

  assign out_o.valid            = ov_q;
  assign out_o.pin_write_enable = o_we_q;
  assign out_o.pin_index        = o_idx_q;
  assign out_o.pin_write_value  = o_wval_q;
  assign out_o.next_line        = o_line_q;
  assign out_o.fault            = o_fault_q;

  // Row of stack cells; cell 0 is the top of stack.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = top_in;
    end else begin : g_mid
      assign above = cell_val[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign below = cell_val[i];
    end else begin : g_inner
      assign below = cell_val[i+1];
    end
    plsm_cell u_cell (
      .clk_i   (clk_i),
      .cmd_i   ((i == 0) ? cmd_top : cmd_rest),
      .above_i (above),
      .below_i (below),
      .value_o (cell_val[i])
    );
  end

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench of the pin logic stack machine: driver, monitor and predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import plsm_pkg::*;

  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam logic [PADDR_W-1:0] PLEN_ADDR  = {REG_PROGRAM_LENGTH, 2'b00};
  localparam logic [PADDR_W-1:0] SPARE_ADDR = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [ARG_W-1:0]    instr_arg;
    logic [WORD_W-1:0]   pin_value;
  } instr_t;

  typedef struct packed {
    logic                pin_write_enable;
    logic [ARG_W-1:0]    pin_index;
    logic [WORD_W-1:0]   pin_write_value;
    logic [LINE_W-1:0]   next_line;
    logic [FAULT_W-1:0]  fault;
  } pin_result_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_TOGGLE,
    RX_BURSTY
  } rx_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  plsm_in_if  instr_if();
  plsm_out_if res_if();

  pin_logic_stack_machine dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (instr_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // Stimulus and expectations.
  instr_t      pending_instrs[$];
  pin_result_t pin_results_q[$];
  int unsigned fail_count = 0;
  bit          instr_taken = 1'b0;
  bit          gap_on = 1'b1;
  int unsigned gen_depth = 0;

  // Predictor state: operand stack, fill level, line counter and program length.
  logic [WORD_W-1:0] pin_stack [DEPTH];
  int unsigned       stack_fill = 0;
  logic [LINE_W-1:0] line_ctr = '0;
  logic [PLEN_W-1:0] prog_len = PLEN_W'(1);

  // Executes one instruction on the predicted machine state.
  task automatic step_pin_machine(input instr_t it, output pin_result_t r);
    int unsigned       n;
    logic [WORD_W-1:0] acc;
    logic [PLEN_W-1:0] nxt;
    r = '0;
    case (it.opcode)
      OP_READ: begin
        r.pin_index = it.instr_arg;
        if (stack_fill >= DEPTH) begin
          r.fault = FAULT_OVER;
        end else begin
          pin_stack[stack_fill] = it.pin_value;
          stack_fill++;
        end
      end
      OP_SET: begin
        r.pin_index = it.instr_arg;
        if (stack_fill == 0) begin
          r.fault = FAULT_UNDER;
        end else begin
          stack_fill--;
          r.pin_write_value  = pin_stack[stack_fill];
          r.pin_write_enable = 1'b1;
        end
      end
      OP_OR, OP_AND: begin
        n = (it.instr_arg == '0) ? 1 : it.instr_arg;
        if (stack_fill < n) begin
          r.fault = FAULT_UNDER;
        end else begin
          acc = pin_stack[stack_fill-1];
          for (int k = 2; k <= n; k++) begin
            acc = (it.opcode == OP_OR) ? (acc | pin_stack[stack_fill-k])
                                       : (acc & pin_stack[stack_fill-k]);
          end
          stack_fill -= n;
          pin_stack[stack_fill] = acc;
          stack_fill++;
        end
      end
      default: ;
    endcase
    // The line counter advances on every instruction, faulted or not.
    nxt = {1'b0, line_ctr} + PLEN_W'(1);
    if (nxt >= prog_len || nxt >= PROGRAM_LINES) nxt = '0;
    line_ctr    = nxt[LINE_W-1:0];
    r.next_line = line_ctr;
  endtask

  // Stack fill after an instruction, as the generator sees it.
  function automatic int unsigned depth_after(instr_t it, int unsigned d);
    int unsigned n;
    n = (it.instr_arg == '0) ? 1 : it.instr_arg;
    case (it.opcode)
      OP_READ:       return (d < DEPTH) ? d + 1 : d;
      OP_SET:        return (d > 0) ? d - 1 : d;
      OP_OR, OP_AND: return (d >= n) ? d - n + 1 : d;
      default:       return d;
    endcase
  endfunction

  task automatic queue_instr(input logic [OPCODE_W-1:0] op, input logic [ARG_W-1:0] arg,
                             input logic [WORD_W-1:0] level);
    instr_t it;
    it.opcode    = op;
    it.instr_arg = arg;
    it.pin_value = level;
    gen_depth = depth_after(it, gen_depth);
    pending_instrs.push_back(it);
  endtask

  // Mostly well-formed instructions for the current fill, with some noise.
  task automatic queue_random_instr();
    int unsigned pick;
    int unsigned n;
    logic [OPCODE_W-1:0] op;
    logic [ARG_W-1:0]    arg;
    logic [WORD_W-1:0]   level;
    pick  = $urandom_range(0, 99);
    op    = OPCODE_W'($urandom);
    arg   = ARG_W'($urandom);
    case ($urandom_range(0, 3))
      0: level = $urandom;
      1: level = $urandom | $urandom;
      2: level = $urandom & $urandom;
      default: level = $urandom_range(0, 1) ? '1 : '0;
    endcase
    if (pick < 42 || (pick < 88 && gen_depth == 0)) begin
      op = OP_READ;
    end else if (pick < 62) begin
      op = OP_SET;
    end else if (pick < 88) begin
      op  = $urandom_range(0, 1) ? OP_OR : OP_AND;
      n   = $urandom_range(1, gen_depth);
      arg = (n == 1 && $urandom_range(0, 1)) ? '0 : ARG_W'(n);
    end
    queue_instr(op, arg, level);
  endtask

  // Register write over the configuration port; the predictor follows it.
  task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == PLEN_ADDR) prog_len = data[PLEN_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Waits until every queued instruction has been sent and every result has come back.
  // Polled at the rising edge, where the driver's last update has settled.
  task automatic wait_drained();
    while (pending_instrs.size() != 0 || instr_if.valid || pin_results_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Instruction driver: bursts of beats separated by random gaps in phases with gaps on.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    instr_t it;
    if (!rst_ni) begin
      instr_if.valid <= 1'b0;
    end else if (!instr_if.valid || instr_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        instr_if.valid <= 1'b0;
      end else if (pending_instrs.size() > 0) begin
        it = pending_instrs.pop_front();
        instr_if.valid     <= 1'b1;
        instr_if.opcode    <= it.opcode;
        instr_if.instr_arg <= it.instr_arg;
        instr_if.pin_value <= it.pin_value;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = gap_on ? $urandom_range(0, 6) : 0;
        end
      end else begin
        instr_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver: back-pressure pattern that is redrawn at random.
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  int unsigned rx_stall = 0;

  always @(negedge clk_i) begin
    logic rdy;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 120);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:   rdy = 1'b1;
      RX_COIN:   rdy = $urandom_range(0, 1);
      RX_TOGGLE: rdy = ~res_if.ready;
      default: begin
        if (rx_stall > 0) begin
          rx_stall--;
          rdy = 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall = $urandom_range(5, 20);
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
        end
      end
    endcase
    res_if.ready <= rdy;
  end

  // Monitor: predicts on each accepted instruction beat, checks each result beat.
  always @(posedge clk_i) begin
    pin_result_t want;
    instr_t      it;
    if (!rst_ni) begin
      instr_taken = 1'b0;
    end else begin
      instr_taken = instr_if.valid && instr_if.ready;
      if (instr_taken) begin
        it.opcode    = instr_if.opcode;
        it.instr_arg = instr_if.instr_arg;
        it.pin_value = instr_if.pin_value;
        step_pin_machine(it, want);
        pin_results_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        if (pin_results_q.size() == 0) begin
          $error("result beat with no instruction outstanding");
          fail_count++;
        end else begin
          want = pin_results_q.pop_front();
          if (res_if.pin_write_enable !== want.pin_write_enable) begin
            $error("pin_write_enable expected %0d got %0d",
                   want.pin_write_enable, res_if.pin_write_enable);
            fail_count++;
          end
          if (res_if.pin_index !== want.pin_index) begin
            $error("pin_index expected %0d got %0d", want.pin_index, res_if.pin_index);
            fail_count++;
          end
          if (res_if.pin_write_value !== want.pin_write_value) begin
            $error("pin_write_value expected %08h got %08h",
                   want.pin_write_value, res_if.pin_write_value);
            fail_count++;
          end
          if (res_if.next_line !== want.next_line) begin
            $error("next_line expected %0d got %0d", want.next_line, res_if.next_line);
            fail_count++;
          end
          if (res_if.fault !== want.fault) begin
            $error("fault expected %0d got %0d", want.fault, res_if.fault);
            fail_count++;
          end
        end
      end
    end
  end

  // Main sequence: reset, directed instructions, then random phases under several
  // program lengths.
  initial begin
    logic [PLEN_W-1:0] phase_len [8];
    int unsigned       phase_items [8];
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    instr_if.valid     = 1'b0;
    instr_if.opcode    = '0;
    instr_if.instr_arg = '0;
    instr_if.pin_value = '0;
    res_if.ready       = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: underflow on an empty stack, no-ops, filling to overflow, merging all.
    write_reg(PLEN_ADDR, 32'd7);
    queue_instr(OP_SET, 8'd0, '0);
    queue_instr(OP_OR, 8'd0, '1);
    queue_instr(OP_AND, 8'd255, '0);
    queue_instr(3'd4, 8'd255, '1);
    queue_instr(3'd7, 8'd0, '0);
    for (int i = 0; i < 17; i++) begin
      queue_instr(OP_READ, (i == 16) ? 8'd255 : ARG_W'(i * 15),
                  (i == 0) ? '1 : (i == 1) ? '0 : WORD_W'($urandom));
    end
    queue_instr(OP_AND, ARG_W'(DEPTH), '0);
    queue_instr(OP_OR, 8'd0, '0);
    queue_instr(OP_SET, 8'd255, '0);
    wait_drained();

    // Random phases; the longer ones let the line counter wrap at 255.
    phase_len   = '{9'd2, 9'd0, 9'd511, 9'd1, 9'd3, 9'd256, 9'd255,
                    PLEN_W'($urandom_range(4, 200))};
    phase_items = '{60, 40, 300, 40, 60, 300, 150, 100};
    for (int p = 0; p < 8; p++) begin
      if (phase_len[p] == 9'd511) begin
        write_reg(PLEN_ADDR, '1);
      end else begin
        write_reg(PLEN_ADDR, PDATA_W'(phase_len[p]));
      end
      // A write to an unused address must leave the program length alone.
      if (p == 4) write_reg(SPARE_ADDR, $urandom);
      gap_on = (p % 2 == 0);
      for (int i = 0; i < phase_items[p]; i++) queue_random_instr();
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("pin_logic_stack_machine: match");
    end else begin
      $display("pin_logic_stack_machine: mismatch");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("pin_logic_stack_machine: mismatch");
    $finish;
  end

endmodule

// ===== pin_logic_stack_machine.f =====
hw/rtl/plsm_pkg.sv
hw/rtl/plsm_if.sv
hw/rtl/plsm_cell.sv
hw/rtl/pin_logic_stack_machine.sv
dv/tb_top.sv
